>>> sv/bfps_pkg.sv
// shared constants and codes for the bloom filter profile scorer
package bfps_pkg;

  localparam int FILTER_WORD_ADDR_BITS = 16;
  localparam int WEIGHT_ADDR_BITS      = 16;

  localparam logic [31:0] MM_MUL = 32'h5bd1e995;
  localparam logic [31:0] SEED_A = 32'd1;
  localparam logic [31:0] SEED_B = 32'd5;
  localparam logic [31:0] KEY_LEN = 32'd3;

  // actions
  localparam logic [1:0] ACT_LOAD_FILTER = 2'd0;
  localparam logic [1:0] ACT_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] ACT_SCORE       = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W       = 2;
  localparam logic [1:0]  REG_DOC_TAG     = 2'd0;
  localparam logic [1:0]  REG_FILTER_BITS = 2'd1;
  localparam int          CFG_DATA_W      = 24;

  typedef logic [FILTER_WORD_ADDR_BITS-1:0] filt_addr_t;
  typedef logic [WEIGHT_ADDR_BITS-1:0]      wgt_addr_t;

endpackage

>>> sv/bloom_filter_profile_scorer_unit.sv
// top level: sequencer, probe logic and score accumulator of the bloom filter scorer
//
//  channel   signals                                          handshake
//  input     start busy action table_index table_data          start & !busy
//            word_id frequency doc_last
//  result    done doc_score false_hits words_seen              done, one cycle, no stall
//  config    cfg_valid cfg_ready cfg_index cfg_data            cfg_valid & cfg_ready
//
//  a load or ignored transaction leaves busy low.
//  a score transaction holds busy high through two chained hash multiplies,
//  the probe add, then two reads of the single filter read port and the accumulate.
//  the result strobe is registered in the accumulate state of a last word.
//  reset is synchronous; the memories are not cleared and need no clearing pass.
//  the receiver cannot stall, cfg_ready is always high.
module bloom_filter_profile_scorer_unit import bfps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  logic [15:0]          table_index,
  input  logic [63:0]          table_data,
  input  logic [23:0]          word_id,
  input  logic [7:0]           frequency,
  input  logic                 doc_last,
  output logic                 done,
  output logic [63:0]          doc_score,
  output logic [31:0]          false_hits,
  output logic [31:0]          words_seen,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_H1   = 3'd1;
  localparam logic [2:0] S_H2   = 3'd2;
  localparam logic [2:0] S_PRB  = 3'd3;
  localparam logic [2:0] S_RD1  = 3'd4;
  localparam logic [2:0] S_RD2  = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_ACC  = 3'd7;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        accept;

  logic [23:0] doc_tag;
  logic [4:0]  filter_bits_log2;

  logic [23:0] id_r;
  logic [7:0]  freq_r;
  logic        last_r;
  logic        is_tag_r;
  logic [31:0] p1_r;
  logic [31:0] p2_r;
  logic        bit1_r;
  logic        hit_r;
  logic        zero_r;
  logic [63:0] prod_r;

  logic [63:0] score_acc;
  logic [31:0] false_hit_count;
  logic [31:0] word_count;
  logic [63:0] score_sum;
  logic [31:0] fh_sum;
  logic [31:0] wc_sum;

  logic [31:0] ha;
  logic [31:0] hb;
  logic [31:0] mask;
  logic [31:0] filt_rdata;
  logic [63:0] wgt_rdata;
  filt_addr_t  filt_raddr;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      doc_tag          <= 24'hFFFFFF;
      filter_bits_log2 <= 5'd21;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DOC_TAG:     doc_tag          <= cfg_data;
        REG_FILTER_BITS: filter_bits_log2 <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  bfps_hash u_hash (
    .clk (clk),
    .key (id_r),
    .ha  (ha),
    .hb  (hb)
  );

  // second probe reuses the read port in the state after the first
  assign filt_raddr = (state == S_RD2) ? p2_r[5 +: FILTER_WORD_ADDR_BITS]
                                       : p1_r[5 +: FILTER_WORD_ADDR_BITS];

  bfps_store u_store (
    .clk        (clk),
    .filt_we    (accept && (action == ACT_LOAD_FILTER)),
    .filt_waddr (filt_addr_t'(table_index)),
    .filt_wdata (table_data[31:0]),
    .filt_raddr (filt_raddr),
    .filt_rdata (filt_rdata),
    .wgt_we     (accept && (action == ACT_LOAD_WEIGHT)),
    .wgt_waddr  (wgt_addr_t'(table_index)),
    .wgt_wdata  (table_data),
    .wgt_raddr  (id_r[WEIGHT_ADDR_BITS-1:0]),
    .wgt_rdata  (wgt_rdata)
  );

  assign mask = ~(32'hFFFFFFFF << filter_bits_log2);

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = (accept && (action == ACT_SCORE)) ? S_H1 : S_IDLE;
      S_H1:    state_next = S_H2;
      S_H2:    state_next = S_PRB;
      S_PRB:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_CHK;
      S_CHK:   state_next = S_ACC;
      S_ACC:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r     <= word_id;
      freq_r   <= frequency;
      last_r   <= doc_last;
      is_tag_r <= (word_id == doc_tag);
    end
    if (state == S_PRB) begin
      p1_r <= ha & mask;
      p2_r <= (ha + hb) & mask;
    end
    if (state == S_RD2) begin
      bit1_r <= filt_rdata[p1_r[4:0]];
    end
    if (state == S_CHK) begin
      hit_r  <= !is_tag_r && bit1_r && filt_rdata[p2_r[4:0]];
      zero_r <= (wgt_rdata == 64'd0);
      prod_r <= wgt_rdata * {56'd0, freq_r};
    end
  end

  assign score_sum = score_acc + (hit_r ? prod_r : 64'd0);
  assign fh_sum    = false_hit_count + {31'd0, hit_r && zero_r};
  assign wc_sum    = word_count + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_acc       <= 64'd0;
      false_hit_count <= 32'd0;
      word_count      <= 32'd0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == S_ACC) begin
        false_hit_count <= fh_sum;
        word_count      <= wc_sum;
        if (last_r) begin
          score_acc <= 64'd0;
          done      <= 1'b1;
        end else begin
          score_acc <= score_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_ACC) && last_r) begin
      doc_score  <= score_sum;
      false_hits <= fh_sum;
      words_seen <= wc_sum;
    end
  end

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past((state == S_ACC) && last_r))
    else $error("result strobe without a finished last word");

  a_score_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_SCORE)) |=> (state == S_H1))
    else $error("score transaction did not start the sequence");

  a_false_hit_step: assert property (@(posedge clk) disable iff (rst)
    (false_hit_count != $past(false_hit_count)) |->
      ($past(state == S_ACC) && (false_hit_count == $past(false_hit_count) + 32'd1)))
    else $error("false hit count moved outside the accumulate step");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

>>> sv/bfps_hash.sv
// two-lane murmurhash2 pipeline over a 24-bit key, one register after each multiply
module bfps_hash import bfps_pkg::*; (
  input  logic        clk,
  input  logic [23:0] key,
  output logic [31:0] ha,
  output logic [31:0] hb
);

  logic [31:0] m1_a;
  logic [31:0] m1_b;
  logic [31:0] m2_a;
  logic [31:0] m2_b;
  logic [31:0] x_a;
  logic [31:0] x_b;

  assign x_a = m1_a ^ (m1_a >> 13);
  assign x_b = m1_b ^ (m1_b >> 13);

  // the key stays stable while a word is scored, so the stages just free-run
  always_ff @(posedge clk) begin
    m1_a <= ((SEED_A ^ KEY_LEN) ^ {8'h00, key}) * MM_MUL;
    m1_b <= ((SEED_B ^ KEY_LEN) ^ {8'h00, key}) * MM_MUL;
    m2_a <= x_a * MM_MUL;
    m2_b <= x_b * MM_MUL;
  end

  assign ha = m2_a ^ (m2_a >> 15);
  assign hb = m2_b ^ (m2_b >> 15);

endmodule

>>> sv/bfps_store.sv
// filter and weight memories, one write and one registered read port each
module bfps_store import bfps_pkg::*; (
  input  logic        clk,
  input  logic        filt_we,
  input  filt_addr_t  filt_waddr,
  input  logic [31:0] filt_wdata,
  input  filt_addr_t  filt_raddr,
  output logic [31:0] filt_rdata,
  input  logic        wgt_we,
  input  wgt_addr_t   wgt_waddr,
  input  logic [63:0] wgt_wdata,
  input  wgt_addr_t   wgt_raddr,
  output logic [63:0] wgt_rdata
);

  logic [31:0] filt_mem [2**FILTER_WORD_ADDR_BITS];
  logic [63:0] wgt_mem  [2**WEIGHT_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (filt_we) begin
      filt_mem[filt_waddr] <= filt_wdata;
    end
    filt_rdata <= filt_mem[filt_raddr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= wgt_wdata;
    end
    wgt_rdata <= wgt_mem[wgt_raddr];
  end

endmodule

>>> tb/bloom_filter_profile_scorer_unit_tb.sv
// self-checking testbench for the bloom filter profile scorer unit
module bloom_filter_profile_scorer_unit_tb;
  import bfps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 475;

  typedef struct {
    logic [1:0]  act;
    logic [15:0] tidx;
    logic [63:0] tdata;
    logic [23:0] key;
    logic [7:0]  freq;
    logic        last;
  } scorer_item_t;

  typedef struct {
    logic [63:0] score;
    logic [31:0] fhits;
    logic [31:0] words;
  } doc_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            action = ACT_LOAD_FILTER;
  logic [15:0]           table_index = '0;
  logic [63:0]           table_data = '0;
  logic [23:0]           word_id = '0;
  logic [7:0]            frequency = '0;
  logic                  doc_last = 1'b0;
  logic                  done;
  logic [63:0]           doc_score;
  logic [31:0]           false_hits;
  logic [31:0]           words_seen;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DOC_TAG;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // scorer state as predicted
  logic [31:0] filter_shadow [int];
  logic [63:0] weight_shadow [int];
  logic [63:0] score_acc;
  logic [31:0] false_hit_count;
  logic [31:0] word_count;
  logic [23:0] tag_cfg;
  logic [4:0]  fbits_cfg;

  doc_result_t pending_docs [$];
  doc_result_t want_doc;
  logic [23:0] id_pool [16];

  int  errors = 0;
  int  items_sent = 0;
  int  docs_checked = 0;
  int  settings_used = 0;
  int  cycles = 0;
  bit  gap_free = 1'b0;

  bloom_filter_profile_scorer_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .table_index (table_index),
    .table_data  (table_data),
    .word_id     (word_id),
    .frequency   (frequency),
    .doc_last    (doc_last),
    .done        (done),
    .doc_score   (doc_score),
    .false_hits  (false_hits),
    .words_seen  (words_seen),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [31:0] murmur_key3(logic [23:0] key, logic [31:0] seed);
    logic [31:0] h;
    h = seed ^ KEY_LEN;
    h = h ^ {8'h00, key};
    h = h * MM_MUL;
    h = h ^ (h >> 13);
    h = h * MM_MUL;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic logic [31:0] probe_bit(logic [23:0] key, bit second);
    logic [31:0] mask;
    logic [31:0] ha;
    mask = (32'd1 << fbits_cfg) - 32'd1;
    ha = murmur_key3(key, SEED_A);
    return second ? ((ha + murmur_key3(key, SEED_B)) & mask) : (ha & mask);
  endfunction

  function automatic int filter_slot(logic [31:0] bitnum);
    return int'(filt_addr_t'(bitnum >> 5));
  endfunction

  function automatic bit bit_set(logic [31:0] bitnum);
    logic [31:0] w;
    w = filter_shadow.exists(filter_slot(bitnum)) ? filter_shadow[filter_slot(bitnum)] : '0;
    return w[bitnum[4:0]];
  endfunction

  task automatic record_item(input scorer_item_t it);
    logic [63:0] w;
    int          slot;
    case (it.act)
      ACT_LOAD_FILTER: filter_shadow[int'(filt_addr_t'(it.tidx))] = it.tdata[31:0];
      ACT_LOAD_WEIGHT: weight_shadow[int'(wgt_addr_t'(it.tidx))] = it.tdata;
      ACT_SCORE: begin
        if (it.key != tag_cfg && bit_set(probe_bit(it.key, 1'b0)) &&
            bit_set(probe_bit(it.key, 1'b1))) begin
          slot = int'(wgt_addr_t'(it.key));
          w = weight_shadow.exists(slot) ? weight_shadow[slot] : '0;
          if (w == '0) false_hit_count++;
          score_acc += w * {56'd0, it.freq};
        end
        word_count++;
        if (it.last) begin
          pending_docs.push_back('{score: score_acc, fhits: false_hit_count,
                                   words: word_count});
          score_acc = '0;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_docs.size() == 0) begin
        $error("result with nothing pending: doc_score %h false_hits %0d words_seen %0d",
               doc_score, false_hits, words_seen);
        errors++;
      end else begin
        want_doc = pending_docs.pop_front();
        docs_checked++;
        if (doc_score !== want_doc.score) begin
          $error("doc_score: expected %h, got %h", want_doc.score, doc_score);
          errors++;
        end
        if (false_hits !== want_doc.fhits) begin
          $error("false_hits: expected %0d, got %0d", want_doc.fhits, false_hits);
          errors++;
        end
        if (words_seen !== want_doc.words) begin
          $error("words_seen: expected %0d, got %0d", want_doc.words, words_seen);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // start stays high across back-to-back transactions
  task automatic send_item(input scorer_item_t it);
    int gap;
    gap = 0;
    if (!gap_free) while ($urandom_range(99) < 23) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= it.act;
    table_index <= it.tidx;
    table_data  <= it.tdata;
    word_id     <= it.key;
    frequency   <= it.freq;
    doc_last    <= it.last;
    do @(posedge clk); while (busy);
    record_item(it);
    items_sent++;
  endtask

  task automatic send_load(input logic [1:0] act, input logic [15:0] idx,
                           input logic [63:0] data);
    send_item('{act: act, tidx: idx, tdata: data, key: 24'($urandom),
                freq: 8'($urandom), last: 1'($urandom)});
  endtask

  // action 3 is ignored by the block
  task automatic send_noise();
    send_item('{act: 2'd3, tidx: 16'($urandom), tdata: {$urandom, $urandom},
                key: 24'($urandom), freq: 8'($urandom), last: 1'($urandom)});
  endtask

  function automatic logic [63:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 22) return '1;
    if (r < 30) return 64'd1;
    if (r < 55) return 64'($urandom_range(1000));
    return {$urandom, $urandom};
  endfunction

  // every entry the block may read for this word is written first unless it is already known
  task automatic prime_word(input logic [23:0] key, input bit want_hit, input bit set_w,
                            input logic [63:0] w);
    logic [31:0] pbit;
    logic [31:0] cur;
    int          slot;
    int          k;
    for (k = 0; k < 2; k++) begin
      pbit = probe_bit(key, k[0]);
      slot = filter_slot(pbit);
      if (want_hit) begin
        cur = filter_shadow.exists(slot) ? filter_shadow[slot] : $urandom;
        cur[pbit[4:0]] = 1'b1;
        if (!filter_shadow.exists(slot) || filter_shadow[slot] != cur)
          send_load(ACT_LOAD_FILTER, 16'(slot), {$urandom, cur});
      end else if (!filter_shadow.exists(slot)) begin
        send_load(ACT_LOAD_FILTER, 16'(slot), {$urandom, $urandom});
      end
    end
    slot = int'(wgt_addr_t'(key));
    if (set_w || !weight_shadow.exists(slot) || $urandom_range(99) < 15)
      send_load(ACT_LOAD_WEIGHT, 16'(slot), set_w ? w : pick_weight());
  endtask

  task automatic score_word(input logic [23:0] key, input logic [7:0] freq, input bit last,
                            input bit want_hit, input bit set_w, input logic [63:0] w);
    prime_word(key, want_hit, set_w, w);
    send_item('{act: ACT_SCORE, tidx: 16'($urandom), tdata: {$urandom, $urandom},
                key: key, freq: freq, last: last});
  endtask

  // hold the sender off until every pending result is back and the pipe is empty
  task automatic drain();
    start <= 1'b0;
    while (pending_docs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] tag, input logic [4:0] fbits);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DOC_TAG;
    cfg_data  <= tag;
    do @(posedge clk); while (!cfg_ready);
    tag_cfg = tag;
    cfg_index <= REG_FILTER_BITS;
    cfg_data  <= CFG_DATA_W'(fbits);
    do @(posedge clk); while (!cfg_ready);
    fbits_cfg = fbits;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_item('{act: 2'd3, tidx: '1, tdata: '1, key: '1, freq: '1, last: 1'b1});
    send_load(ACT_LOAD_FILTER, 16'hffff, '1);
    send_load(ACT_LOAD_WEIGHT, 16'h0000, '0);
    send_load(ACT_LOAD_WEIGHT, 16'hffff, '1);
    // largest weight times largest frequency wraps the score
    score_word(24'h000000, 8'hff, 1'b0, 1'b1, 1'b1, '1);
    // shares its weight slot with id zero
    score_word(24'h010000, 8'h01, 1'b1, 1'b1, 1'b0, '0);
    // reset tag value is never a hit but still counts
    score_word(24'hffffff, 8'hff, 1'b1, 1'b1, 1'b1, 64'd3);
    // hit on a zero weight
    score_word(24'($urandom), 8'd7, 1'b1, 1'b1, 1'b1, '0);
    score_word(24'($urandom), 8'd0, 1'b1, 1'b1, 1'b0, '0);
    score_word(24'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b0, '0);
  endtask

  task automatic test_config_cases();
    drain();
    set_config(24'h000000, 5'd21);
    score_word(24'h000000, 8'd9, 1'b0, 1'b1, 1'b1, 64'd5);
    score_word(24'h000001, 8'd9, 1'b1, 1'b1, 1'b1, 64'd5);
    drain();
    // mask of zero: both probes land on bit zero of word zero
    set_config(24'($urandom), 5'd0);
    score_word(24'($urandom), 8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    score_word(24'($urandom), 8'($urandom), 1'b1, 1'b1, 1'b0, '0);
    drain();
    // filter wider than the store wraps the word address
    set_config(24'hffffff, 5'd31);
    score_word(24'($urandom), 8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    score_word(24'($urandom), 8'($urandom), 1'b1, 1'b1, 1'b0, '0);
    drain();
    set_config(24'hffffff, 5'd5);
    score_word(24'($urandom), 8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    score_word(24'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b0, '0);
    drain();
  endtask

  task automatic test_random_documents();
    logic [23:0] tags [4];
    logic [4:0]  sizes [4];
    logic [23:0] key;
    logic [7:0]  freq;
    int          ph;
    int          target;
    int          n;
    int          j;
    int          r;
    // pairs of ids that differ only above the weight address bits
    for (j = 0; j < 16; j += 2) begin
      id_pool[j]     = 24'($urandom);
      id_pool[j + 1] = {8'($urandom), id_pool[j][15:0]};
    end
    tags[0] = 24'($urandom); sizes[0] = 5'd21;
    tags[1] = id_pool[3];    sizes[1] = 5'd5;
    tags[2] = 24'hffffff;    sizes[2] = 5'($urandom_range(6, 20));
    tags[3] = 24'($urandom); sizes[3] = 5'd13;
    for (ph = 0; ph < 4; ph++) begin
      drain();
      set_config(tags[ph], sizes[ph]);
      gap_free = (ph == 1);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 6) begin
          send_noise();
        end else if (r < 11) begin
          send_load(2'($urandom_range(1)), 16'($urandom), {$urandom, $urandom});
        end else begin
          n = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
          for (j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r < 40) key = id_pool[$urandom_range(15)];
            else if (r < 45) key = tag_cfg;
            else key = 24'($urandom);
            r = $urandom_range(99);
            if (r < 10) freq = 8'hff;
            else if (r < 20) freq = 8'h00;
            else freq = 8'($urandom);
            score_word(key, freq, j == n - 1, $urandom_range(99) < 65, 1'b0, '0);
          end
        end
      end
    end
    gap_free = 1'b0;
  endtask

  initial begin
    score_acc       = '0;
    false_hit_count = '0;
    word_count      = '0;
    tag_cfg         = 24'hffffff;
    fbits_cfg       = 5'd21;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_config_cases();
    test_random_documents();
    drain();
    $display("covered %0d transactions under %0d register settings", items_sent,
             settings_used);
    $display("checked %0d document results, %0d mismatches", docs_checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
